FILE: hdl/wavp_pkg.sv
// ----------------------------------------------------------------------------
// wavp_pkg: shared types and constants
// Phase codes, tags, the command set and the front/back item struct.
// ----------------------------------------------------------------------------
package wavp_pkg;
	localparam logic [1:0] CMD_DATA    = 2'd0;
	localparam logic [1:0] CMD_START   = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_STOP    = 2'd3;

	localparam logic [3:0] PH_HDR   = 4'd4;
	localparam logic [3:0] PH_FMT   = 4'd5;
	localparam logic [3:0] PH_CHUNK = 4'd6;
	localparam logic [3:0] PH_SKIP  = 4'd7;
	localparam logic [3:0] PH_JUNK  = 4'd8;
	localparam logic [3:0] PH_STOP  = 4'd9;
	localparam logic [3:0] PH_ERR1  = 4'd10;
	localparam logic [3:0] PH_ERR2  = 4'd11;
	localparam logic [3:0] PH_ERR3  = 4'd12;

	localparam logic [31:0] TAG_RIFF = 32'h46464952;
	localparam logic [31:0] TAG_WAVE = 32'h45564157;
	localparam logic [31:0] TAG_FMT  = 32'h20746D66;
	localparam logic [31:0] TAG_DATA = 32'h61746164;

	localparam logic [31:0] RATE_44K = 32'd44100;
	localparam logic [31:0] RATE_22K = 32'd22050;
	localparam logic [31:0] RATE_11K = 32'd11025;
	localparam logic [31:0] FMT_MIN  = 32'd16;

	// item handed from the parser to the timing back end
	typedef struct packed {
		logic        audio_valid;
		logic [7:0]  audio_byte;
		logic        audio_last;
		logic        playing;
		logic [1:0]  play_mode;
		logic [1:0]  rate_code;
		logic [1:0]  error_code;
		logic [31:0] start_offset;
		logic [31:0] done_bytes;
		logic [31:0] total_bytes;
		logic [31:0] byte_scale;
	} wavp_item_t;
endpackage

FILE: hdl/wav_header_parse_and_pass_top.sv
// ----------------------------------------------------------------------------
// wav_header_parse_and_pass_top: RIFF/WAVE header parser with audio pass
// One byte item per cycle in; one result item per input item out.
// Path: input accept writes a queue slot, the slot pops into stage 1, and the
//   multiply registers into the output stage; a result stall can hold each step.
// Throughput: 1 item per cycle; input stalls only while the 2-entry queue is full.
// Reset: arst_n clears all control state; phase stopped, scale base 97352592.
// ----------------------------------------------------------------------------
module wav_header_parse_and_pass_top import wavp_pkg::*; #(
	parameter int HEADER_BYTES = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,      // ms_scale_base
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,       // [7:0] data_byte
	input  logic [1:0]   s_tuser,       // [1:0] cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,       // [7:0] audio_byte, [9:8] play_mode,
	                                    // [11:10] rate_code, [13:12] error_code,
	                                    // [45:14] audio_start_offset,
	                                    // [77:46] position_ms, [109:78] length_ms
	output logic [1:0]   m_tuser,       // [0] audio_valid, [1] playing
	output logic         m_tlast        // audio_last
);
	logic [31:0] base_q;
	wavp_item_t  f_item, q_item;
	logic        q_nf, q_ne, q_pop, in_fire;
	logic [2:0]  usr;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) base_q <= 32'd97352592;
		else if (cfg_valid) base_q <= cfg_data;
	end

	// queue slot frees as the back end pops; parser accepts whenever room
	assign s_tready = q_nf;
	assign in_fire  = s_tvalid && s_tready;

	wavp_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .cmd(s_tuser),
		.data_byte(s_tdata), .ms_scale_base(base_q), .item(f_item)
	);

	wavp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(in_fire), .wr_item(f_item),
		.not_full(q_nf), .rd_en(q_pop), .not_empty(q_ne), .rd_item(q_item)
	);

	wavp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_ne), .q_item(q_item), .q_pop(q_pop),
		.m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata), .m_user(usr)
	);

	assign m_tuser = usr[1:0];
	assign m_tlast = usr[2];

	// no pop from an empty queue
	a_pop: assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_ne)
		else $error("pop on empty queue");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	// audio only while playing
	a_play: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[1] || m_tlast)
		else $error("audio outside play");
endmodule

FILE: hdl/wavp_front.sv
// ----------------------------------------------------------------------------
// wavp_front: header parser
// Consumes one byte item per cycle while in_fire is high, walks the RIFF chunk structure.
// ----------------------------------------------------------------------------
module wavp_front import wavp_pkg::*; #(
	parameter int HEADER_BYTES = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [1:0]       cmd,
	input  logic [7:0]       data_byte,
	input  logic [31:0]      ms_scale_base,
	output wavp_item_t       item
);
	localparam int PW = (HEADER_BYTES > 32) ? 6 : 5;

	logic [7:0]  hs_q [HEADER_BYTES];
	logic [3:0]  phase_q;
	logic [31:0] rem_q, total_q, scale_q, offs_q;
	logic [5:0]  pos_q;
	logic [1:0]  mode_q, rate_q;

	logic [3:0]  ph_n;
	logic [31:0] rem_n, total_n, scale_n, offs_n;
	logic [5:0]  pos_n;
	logic [1:0]  mode_n, rate_n;
	logic        wr_en;
	logic        av, al;
	logic [7:0]  ab;

	// header word view, with the incoming byte bypassed into its slot
	function automatic logic [7:0] hb(input logic [5:0] k, input logic [7:0] nb,
		input logic en, input logic [5:0] wp, input logic [7:0] st [HEADER_BYTES]);
		logic [7:0] r;
		r = 8'd0;
		if (32'(k) < HEADER_BYTES) r = (en && k == wp) ? nb : st[k[PW-1:0]];
		return r;
	endfunction

	// header store write: data byte in a collecting phase, slot in range
	assign wr_en = (cmd == CMD_DATA) && (phase_q inside {PH_HDR, PH_FMT, PH_CHUNK}) &&
	               (32'(pos_q) < HEADER_BYTES);

	logic [31:0] w0, w4, w8, w12, w16;
	always_comb begin
		w0  = {hb(6'd3, data_byte, wr_en, pos_q, hs_q), hb(6'd2, data_byte, wr_en, pos_q, hs_q),
		       hb(6'd1, data_byte, wr_en, pos_q, hs_q), hb(6'd0, data_byte, wr_en, pos_q, hs_q)};
		w4  = {hb(6'd7, data_byte, wr_en, pos_q, hs_q), hb(6'd6, data_byte, wr_en, pos_q, hs_q),
		       hb(6'd5, data_byte, wr_en, pos_q, hs_q), hb(6'd4, data_byte, wr_en, pos_q, hs_q)};
		w8  = {hb(6'd11, data_byte, wr_en, pos_q, hs_q), hb(6'd10, data_byte, wr_en, pos_q, hs_q),
		       hb(6'd9, data_byte, wr_en, pos_q, hs_q), hb(6'd8, data_byte, wr_en, pos_q, hs_q)};
		w12 = {hb(6'd15, data_byte, wr_en, pos_q, hs_q), hb(6'd14, data_byte, wr_en, pos_q, hs_q),
		       hb(6'd13, data_byte, wr_en, pos_q, hs_q), hb(6'd12, data_byte, wr_en, pos_q, hs_q)};
		w16 = {hb(6'd19, data_byte, wr_en, pos_q, hs_q), hb(6'd18, data_byte, wr_en, pos_q, hs_q),
		       hb(6'd17, data_byte, wr_en, pos_q, hs_q), hb(6'd16, data_byte, wr_en, pos_q, hs_q)};
	end

	logic [31:0] rem_dec;
	assign rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;

	always_comb begin
		logic [31:0] sc;
		logic        ok;
		logic [1:0]  md;
		ph_n = phase_q; rem_n = rem_q; total_n = total_q; scale_n = scale_q;
		offs_n = offs_q; pos_n = pos_q; mode_n = mode_q; rate_n = rate_q;
		av = 1'b0; ab = 8'd0; al = 1'b0;
		sc = 32'd0; ok = 1'b0; md = 2'd0;
		case (cmd)
			CMD_START: begin
				ph_n = PH_HDR; rem_n = 32'd20; pos_n = 6'd0; offs_n = 32'd0;
			end
			CMD_RESTART: begin
				rem_n = total_q;
				ph_n = (total_q == 32'd0) ? PH_STOP : {2'b00, mode_q};
			end
			CMD_STOP: begin
				ph_n = PH_STOP; rem_n = 32'd0;
			end
			default: begin
				if (phase_q inside {PH_HDR, PH_FMT, PH_CHUNK}) begin
					offs_n = offs_q + 32'd1;
					pos_n = pos_q + 6'd1;
					rem_n = rem_dec;
				end
				case (phase_q)
					PH_HDR: begin
						if (rem_dec == 32'd0) begin
							if (w0 != TAG_RIFF || w8 != TAG_WAVE) ph_n = PH_ERR1;
							else if (w12 == TAG_FMT) begin
								if (w16 < FMT_MIN || w16 > 32'(HEADER_BYTES)) ph_n = PH_ERR2;
								else begin
									ph_n = PH_FMT; rem_n = w16; pos_n = 6'd0;
								end
							end else if (w16 == 32'd0) begin
								ph_n = PH_HDR; rem_n = 32'd8; pos_n = 6'd12;
							end else begin
								ph_n = PH_JUNK; rem_n = w16;
							end
						end
					end
					PH_FMT: begin
						if (rem_dec == 32'd0) begin
							ok = 1'b1;
							if (w0[15:0] != 16'd1) ok = 1'b0;
							else begin
								if (w4 == RATE_44K) begin
									sc = ms_scale_base; rate_n = 2'd3;
								end else if (w4 == RATE_22K) begin
									sc = {ms_scale_base[30:0], 1'b0}; rate_n = 2'd2;
								end else if (w4 == RATE_11K) begin
									sc = {ms_scale_base[29:0], 2'b00}; rate_n = 2'd1;
								end else begin
									rate_n = 2'd0; ok = 1'b0;
								end
								if (ok) begin
									if (w0[31:16] == 16'd2) begin
										sc = sc >> 1; md[0] = 1'b1;
									end else if (w0[31:16] != 16'd1) ok = 1'b0;
								end
								if (ok) begin
									if (w12[31:16] == 16'd16) begin
										sc = sc >> 1; md[1] = 1'b1;
									end else if (w12[31:16] != 16'd8) ok = 1'b0;
								end
							end
							if (ok) begin
								scale_n = sc; mode_n = md;
								ph_n = PH_CHUNK; rem_n = 32'd8; pos_n = 6'd0;
							end else ph_n = PH_ERR3;
						end
					end
					PH_CHUNK: begin
						if (rem_dec == 32'd0) begin
							if (w0 == TAG_DATA) begin
								total_n = w4; rem_n = w4;
								ph_n = (w4 == 32'd0) ? PH_STOP : {2'b00, mode_q};
							end else if (w4 == 32'd0) begin
								ph_n = PH_CHUNK; rem_n = 32'd8; pos_n = 6'd0;
							end else begin
								ph_n = PH_SKIP; rem_n = w4;
							end
						end
					end
					PH_SKIP, PH_JUNK: begin
						offs_n = offs_q + 32'd1;
						rem_n = rem_dec;
						if (rem_dec == 32'd0) begin
							rem_n = 32'd8;
							if (phase_q == PH_SKIP) begin
								ph_n = PH_CHUNK; pos_n = 6'd0;
							end else begin
								ph_n = PH_HDR; pos_n = 6'd12;
							end
						end
					end
					4'd0, 4'd1, 4'd2, 4'd3: begin
						av = phase_q[1]; ab = data_byte;
						rem_n = rem_dec;
						if (rem_dec == 32'd0) begin
							al = 1'b1; ph_n = PH_STOP;
						end
					end
					default: ;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STOP; rem_q <= '0; total_q <= '0; scale_q <= '0;
			offs_q <= '0; pos_q <= '0; mode_q <= '0; rate_q <= '0;
		end else if (in_fire) begin
			phase_q <= ph_n; rem_q <= rem_n; total_q <= total_n; scale_q <= scale_n;
			offs_q <= offs_n; pos_q <= pos_n; mode_q <= mode_n; rate_q <= rate_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && wr_en) hs_q[pos_q[PW-1:0]] <= data_byte;
	end

	always_comb begin
		item.audio_valid  = av;
		item.audio_byte   = ab;
		item.audio_last   = al;
		item.playing      = (ph_n < PH_HDR);
		item.play_mode    = mode_n;
		item.rate_code    = rate_n;
		item.error_code   = (ph_n > PH_STOP && ph_n <= PH_ERR3) ? 2'(ph_n - PH_STOP) : 2'd0;
		item.start_offset = offs_n;
		item.done_bytes   = total_n - rem_n;
		item.total_bytes  = total_n;
		item.byte_scale   = scale_n;
	end
endmodule

FILE: hdl/wavp_queue.sv
// ----------------------------------------------------------------------------
// wavp_queue: two-entry item queue
// Decouples the parser from the back end; full rate with registered ready.
// ----------------------------------------------------------------------------
module wavp_queue import wavp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  wavp_item_t wr_item,
	output logic       not_full,
	input  logic       rd_en,
	output logic       not_empty,
	output wavp_item_t rd_item
);
	wavp_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign not_full  = (cnt_q != 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign rd_item   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_item;
	end
endmodule

FILE: hdl/wavp_back.sv
// ----------------------------------------------------------------------------
// wavp_back: timing back end
// Two-stage pipeline: input register, then multiply to ms into the output register.
// ----------------------------------------------------------------------------
module wavp_back import wavp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  wavp_item_t   q_item,
	output logic         q_pop,
	output logic         m_valid,
	input  logic         m_ready,
	output logic [111:0] m_data,
	output logic [2:0]   m_user
);
	logic        v_s1, v_s2;
	wavp_item_t  it_s1;
	logic [63:0] pos_s2, len_s2;
	wavp_item_t  it_s2;
	logic        adv2, adv1;

	assign adv2  = !v_s2 || m_ready;
	assign adv1  = !v_s1 || adv2;
	assign q_pop = q_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && q_valid) it_s1 <= q_item;
		if (adv2 && v_s1) begin
			it_s2  <= it_s1;
			pos_s2 <= 64'(it_s1.done_bytes) * 64'(it_s1.byte_scale);
			len_s2 <= 64'(it_s1.total_bytes) * 64'(it_s1.byte_scale);
		end
	end

	assign m_valid = v_s2;
	// tdata: audio_byte, play_mode, rate_code, error_code, offset, position, length
	assign m_data = {2'b00,
	                 it_s2.playing ? len_s2[63:32] : 32'd0,
	                 it_s2.playing ? pos_s2[63:32] : 32'd0,
	                 it_s2.start_offset, it_s2.error_code, it_s2.rate_code,
	                 it_s2.play_mode, it_s2.audio_byte};
	// user: [0] audio_valid, [1] playing, [2] audio_last
	assign m_user = {it_s2.audio_last, it_s2.playing, it_s2.audio_valid};
endmodule
